### rtl/core/gle_pkg.sv
`default_nettype none

package gle_pkg;

	typedef logic [1:0] fsm_state_t;

	localparam fsm_state_t ST_IDLE = 2'd0;
	localparam fsm_state_t ST_DIVG = 2'd1;
	localparam fsm_state_t ST_DIVQ = 2'd2;
	localparam fsm_state_t ST_MUL  = 2'd3;

endpackage

`default_nettype wire

### rtl/core/gcd_lcm_engine_top.sv
// Greatest common divisor and least common multiple of two unsigned operands of
// OPERAND_BITS bits (N). An item is taken when start is high and busy is low; the
// result shows for exactly one cycle with done high and must be captured then, as
// the block cannot be stalled. When either operand is zero the result appears in the
// cycle after the item is taken: the gcd is the other operand, lcm is zero. Otherwise
// the item runs its Euclid remainder steps, then the division of operand_a by the gcd
// and then the final multiply by operand_b; each of these works through all N bits
// on one shared add/subtract unit that settles one bit per cycle, and the result is
// registered at the end of the multiply. On an lcm that does not fit in N bits,
// lcm_value is all ones and lcm_overflow is set. A zero operand leaves busy low;
// else busy is high from the cycle after the item is taken until the result shows.
`default_nettype none

module gcd_lcm_engine_top #(
	parameter int OPERAND_BITS = 63
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	output logic                    busy,
	input  wire  [OPERAND_BITS-1:0] operand_a,
	input  wire  [OPERAND_BITS-1:0] operand_b,
	output logic                    done,
	output logic [OPERAND_BITS-1:0] gcd_value,
	output logic [OPERAND_BITS-1:0] lcm_value,
	output logic                    lcm_overflow
);

	localparam int N  = OPERAND_BITS;
	localparam int CW = $clog2(OPERAND_BITS);
	localparam logic [CW-1:0] LAST = CW'(OPERAND_BITS - 1);

	gle_pkg::fsm_state_t state_q;
	logic [CW-1:0]  cnt_q;
	logic           done_q;

	logic [N-1:0]   a_q;
	logic [N-1:0]   b_q;
	logic [N-1:0]   lo_q;
	logic [N-1:0]   dvd_q;
	logic [N-1:0]   rem_q;
	logic [N-1:0]   acc_q;
	logic           ovf_q;
	logic [N-1:0]   gcd_q;
	logic [N-1:0]   lcm_q;
	logic           lcm_ovf_q;

	logic [N:0]     rem_shift;
	logic [N+1:0]   alu_a;
	logic [N+1:0]   alu_b;
	logic [N+1:0]   alu_sum;
	logic           trial_ok;
	logic [N-1:0]   new_rem;
	logic [N-1:0]   dvd_nxt;
	logic           mul_ovf;
	logic           fin_ovf;
	logic           accept;
	logic           zero_in;
	logic           last;

	assign accept  = start && (state_q == gle_pkg::ST_IDLE);
	assign zero_in = (operand_a == '0) || (operand_b == '0);
	assign last    = (cnt_q == LAST);

	// shared add/subtract unit
	always_comb begin
		rem_shift = {rem_q, dvd_q[N-1]};
		if (state_q == gle_pkg::ST_MUL) begin
			alu_a   = {1'b0, acc_q, 1'b0};
			alu_b   = dvd_q[N-1] ? {2'b00, b_q} : '0;
			alu_sum = alu_a + alu_b;
		end else begin
			alu_a   = {1'b0, rem_shift};
			alu_b   = {2'b00, lo_q};
			alu_sum = alu_a - alu_b;
		end
	end

	assign trial_ok = !alu_sum[N+1];
	assign new_rem  = trial_ok ? alu_sum[N-1:0] : rem_shift[N-1:0];
	assign dvd_nxt  = {dvd_q[N-2:0], trial_ok};
	assign mul_ovf  = (alu_sum[N+1:N] != 2'b00);
	assign fin_ovf  = ovf_q || mul_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gle_pkg::ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				gle_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (zero_in) begin
							done_q <= 1'b1;
						end else begin
							state_q <= gle_pkg::ST_DIVG;
						end
					end
				end
				gle_pkg::ST_DIVG: begin
					if (last) begin
						cnt_q <= '0;
						if (new_rem == '0) begin
							state_q <= gle_pkg::ST_DIVQ;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				gle_pkg::ST_DIVQ: begin
					if (last) begin
						cnt_q   <= '0;
						state_q <= gle_pkg::ST_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				gle_pkg::ST_MUL: begin
					if (last) begin
						cnt_q   <= '0;
						state_q <= gle_pkg::ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= gle_pkg::ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			gle_pkg::ST_IDLE: begin
				if (accept) begin
					a_q <= operand_a;
					b_q <= operand_b;
					if (zero_in) begin
						gcd_q     <= operand_a | operand_b;
						lcm_q     <= '0;
						lcm_ovf_q <= 1'b0;
					end else begin
						lo_q  <= (operand_a >= operand_b) ? operand_b : operand_a;
						dvd_q <= (operand_a >= operand_b) ? operand_a : operand_b;
						rem_q <= '0;
					end
				end
			end
			gle_pkg::ST_DIVG: begin
				if (last) begin
					rem_q <= '0;
					if (new_rem == '0) begin
						dvd_q <= a_q;
					end else begin
						dvd_q <= lo_q;
						lo_q  <= new_rem;
					end
				end else begin
					rem_q <= new_rem;
					dvd_q <= dvd_nxt;
				end
			end
			gle_pkg::ST_DIVQ: begin
				rem_q <= new_rem;
				dvd_q <= dvd_nxt;
				if (last) begin
					acc_q <= '0;
					ovf_q <= 1'b0;
				end
			end
			gle_pkg::ST_MUL: begin
				dvd_q <= {dvd_q[N-2:0], 1'b0};
				if (!ovf_q) begin
					if (mul_ovf) begin
						ovf_q <= 1'b1;
					end else begin
						acc_q <= alu_sum[N-1:0];
					end
				end
				if (last) begin
					gcd_q     <= lo_q;
					lcm_q     <= fin_ovf ? '1 : alu_sum[N-1:0];
					lcm_ovf_q <= fin_ovf;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != gle_pkg::ST_IDLE);
	assign done         = done_q;
	assign gcd_value    = gcd_q;
	assign lcm_value    = lcm_q;
	assign lcm_overflow = lcm_ovf_q;

endmodule

`default_nettype wire

### rtl/core/gle_chk.sv
`default_nettype none

module gle_chk #(
	parameter int OPERAND_BITS = 63
) (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    start,
	input wire                    busy,
	input wire [OPERAND_BITS-1:0] operand_a,
	input wire [OPERAND_BITS-1:0] operand_b,
	input wire                    done,
	input wire [OPERAND_BITS-1:0] gcd_value,
	input wire [OPERAND_BITS-1:0] lcm_value,
	input wire                    lcm_overflow
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("item taken but neither busy nor done");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && lcm_overflow) |-> (lcm_value == {OPERAND_BITS{1'b1}}))
		else $error("overflow without saturated lcm");

	a_zero_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (gcd_value == '0)) |-> ((lcm_value == '0) && !lcm_overflow))
		else $error("zero gcd with nonzero lcm");

	a_rise_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !done)
		else $error("done at start of work");

endmodule

bind gcd_lcm_engine_top gle_chk #(.OPERAND_BITS(OPERAND_BITS)) u_gle_chk (.*);

`default_nettype wire
